>>> design/cmac_pkg.sv
// Shared types, constants and AES helper functions for the CMAC engine.
`default_nettype none
package cmac_pkg;

  localparam int BLOCK_BYTES = 16;
  localparam logic [7:0] SUBKEY_POLY = 8'h87;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [3:0] LAST_ROUND = 4'd10;

  // Configuration register indexes.
  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW = 1'b1;

  // One queued block: padded data, final flag and subkey choice.
  typedef struct packed {
    logic [127:0] data;
    logic         fin;
    logic         use_k2;
  } cmac_item_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Round constant for the key expansion step that yields round key rnd.
  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    logic [7:0] rc;
    case (rnd)
      4'd1: rc = 8'h01;
      4'd2: rc = 8'h02;
      4'd3: rc = 8'h04;
      4'd4: rc = 8'h08;
      4'd5: rc = 8'h10;
      4'd6: rc = 8'h20;
      4'd7: rc = 8'h40;
      4'd8: rc = 8'h80;
      4'd9: rc = 8'h1b;
      4'd10: rc = 8'h36;
      default: rc = 8'h00;
    endcase
    return rc;
  endfunction

  // Next AES-128 round key from the current one.
  function automatic logic [127:0] next_round_key(input logic [127:0] rk, input logic [7:0] rc);
    logic [31:0] tmp;
    logic [31:0] w0, w1, w2, w3;
    tmp = {SBOX[rk[23:16]] ^ rc, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
    w0 = rk[127:96] ^ tmp;
    w1 = rk[95:64] ^ w0;
    w2 = rk[63:32] ^ w1;
    w3 = rk[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  // SubBytes, ShiftRows and, except in the last round, MixColumns.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0] sb [16];
    logic [7:0] t [16];
    logic [7:0] all;
    logic [127:0] res;
    for (int c = 0; c < 4; c++) begin
      for (int q = 0; q < 4; q++) begin
        sb[c*4+q] = SBOX[s[127 - 8*((((c + q) & 3) * 4) + q) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      all = sb[c*4] ^ sb[c*4+1] ^ sb[c*4+2] ^ sb[c*4+3];
      for (int q = 0; q < 4; q++) begin
        t[c*4+q] = last ? sb[c*4+q] :
                   (sb[c*4+q] ^ all ^ xtime(sb[c*4+q] ^ sb[c*4+((q + 1) & 3)]));
      end
    end
    for (int i = 0; i < 16; i++) begin
      res[127 - 8*i -: 8] = t[i];
    end
    return res;
  endfunction

  // One-bit left shift with conditional reduction by 0x87.
  function automatic logic [127:0] dbl(input logic [127:0] v);
    return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? SUBKEY_POLY : 8'h00)};
  endfunction

endpackage
`default_nettype wire

>>> design/cmac_front.sv
// Input side: accepts words, clamps the byte count and pads final blocks.
`default_nettype none
module cmac_front (
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [63:0]          in_data_high,
  input  wire logic [63:0]          in_data_low,
  input  wire logic [4:0]           in_valid_bytes,
  input  wire logic                 in_final_block,
  input  wire logic                 q_full,
  output logic                      q_push,
  output cmac_pkg::cmac_item_t      q_item
);
  import cmac_pkg::*;

  logic [4:0]   nbytes;
  logic [127:0] raw;
  logic [127:0] padded;

  assign in_ready = !q_full;
  assign q_push = in_valid && !q_full;
  assign raw = {in_data_high, in_data_low};

  // A count above a full block counts as a full block.
  assign nbytes = (in_valid_bytes > 5'(BLOCK_BYTES)) ? 5'(BLOCK_BYTES) : in_valid_bytes;

  // Keep message bytes, put the pad marker after them and zero the rest.
  always_comb begin
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      if (5'(i) < nbytes) begin
        padded[127 - 8*i -: 8] = raw[127 - 8*i -: 8];
      end else if (5'(i) == nbytes) begin
        padded[127 - 8*i -: 8] = PAD_BYTE;
      end else begin
        padded[127 - 8*i -: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    q_item.fin = in_final_block;
    q_item.use_k2 = in_final_block && (nbytes != 5'(BLOCK_BYTES));
    q_item.data = q_item.use_k2 ? padded : raw;
  end

endmodule
`default_nettype wire

>>> design/cmac_fifo.sv
// Two-entry queue between the input side and the cipher core.
`default_nettype none
module cmac_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire cmac_pkg::cmac_item_t push_item,
  output logic                      full,
  output logic                      not_empty,
  input  wire logic                 pop,
  output cmac_pkg::cmac_item_t      head
);
  import cmac_pkg::*;

  cmac_item_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

>>> design/cmac_core.sv
// Cipher core: iterative AES-128, CBC chain, subkey base and tag register.
`default_nettype none
module cmac_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [63:0]          cfg_wdata,
  input  wire logic                 q_not_empty,
  input  wire cmac_pkg::cmac_item_t q_head,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [63:0]               out_tag_high,
  output logic [63:0]               out_tag_low
);
  import cmac_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN = 1'b1;

  logic         st_r, st_nxt;
  logic [3:0]   rnd_r, rnd_nxt;
  logic [127:0] aes_r, aes_nxt;
  logic [127:0] rk_r, rk_nxt;
  logic         lgen_r, lgen_nxt;
  logic         fin_r, fin_nxt;
  logic [127:0] key_r;
  logic [127:0] chain_r, chain_nxt;
  logic [127:0] l_r, l_nxt;
  logic         l_ready_r, l_ready_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [127:0] tag_r, tag_nxt;

  logic [127:0] rk_step;
  logic [127:0] aes_step;
  logic [127:0] k1, subkey;
  logic         out_free;
  logic         start_lgen;
  logic         last_rnd;

  assign out_valid = out_valid_r;
  assign out_tag_high = tag_r[127:64];
  assign out_tag_low = tag_r[63:0];
  assign out_free = !out_valid_r || out_ready;
  assign last_rnd = (rnd_r == LAST_ROUND);

  // One AES round and one key expansion step per cycle in ST_RUN, unless a finished tag waits for the output register.
  assign rk_step = next_round_key(rk_r, rcon(rnd_r));
  assign aes_step = aes_round(aes_r, last_rnd) ^ rk_step;

  // Subkeys from L.
  assign k1 = dbl(l_r);
  assign subkey = q_head.use_k2 ? dbl(k1) : k1;

  // A final word needs L for the current key before it can start.
  assign start_lgen = (st_r == ST_IDLE) && q_not_empty && q_head.fin && !l_ready_r;
  assign q_pop = (st_r == ST_IDLE) && q_not_empty && !start_lgen;

  // Sequencer: load a block (or the key, to compute L), run ten rounds, then retire the result.
  always_comb begin
    st_nxt = st_r;
    rnd_nxt = rnd_r;
    aes_nxt = aes_r;
    rk_nxt = rk_r;
    lgen_nxt = lgen_r;
    fin_nxt = fin_r;
    chain_nxt = chain_r;
    l_nxt = l_r;
    l_ready_nxt = l_ready_r;
    out_valid_nxt = out_valid_r && !out_ready;
    tag_nxt = tag_r;
    unique case (st_r)
      ST_IDLE: begin
        if (start_lgen) begin
          aes_nxt = key_r;
          rk_nxt = key_r;
          rnd_nxt = 4'd1;
          lgen_nxt = 1'b1;
          fin_nxt = 1'b0;
          st_nxt = ST_RUN;
        end else if (q_pop) begin
          aes_nxt = chain_r ^ q_head.data ^ key_r ^ (q_head.fin ? subkey : 128'd0);
          rk_nxt = key_r;
          rnd_nxt = 4'd1;
          lgen_nxt = 1'b0;
          fin_nxt = q_head.fin;
          st_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!last_rnd) begin
          aes_nxt = aes_step;
          rk_nxt = rk_step;
          rnd_nxt = rnd_r + 4'd1;
        end else if (lgen_r) begin
          l_nxt = aes_step;
          l_ready_nxt = 1'b1;
          st_nxt = ST_IDLE;
        end else if (fin_r) begin
          // Hold the finished tag until the output register is free.
          if (out_free) begin
            tag_nxt = aes_step;
            out_valid_nxt = 1'b1;
            chain_nxt = 128'd0;
            st_nxt = ST_IDLE;
          end
        end else begin
          chain_nxt = aes_step;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    // A key write makes L stale.
    if (cfg_we) begin
      l_ready_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      chain_r <= 128'd0;
      l_ready_r <= 1'b0;
      out_valid_r <= 1'b0;
      key_r <= 128'd0;
    end else begin
      st_r <= st_nxt;
      chain_r <= chain_nxt;
      l_ready_r <= l_ready_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_KEY_HIGH) begin
          key_r[127:64] <= cfg_wdata;
        end else begin
          key_r[63:0] <= cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rnd_r <= rnd_nxt;
    aes_r <= aes_nxt;
    rk_r <= rk_nxt;
    lgen_r <= lgen_nxt;
    fin_r <= fin_nxt;
    l_r <= l_nxt;
    tag_r <= tag_nxt;
  end

  // The round counter stays within the ten rounds while running.
  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RUN) |-> (rnd_r >= 4'd1 && rnd_r <= LAST_ROUND))
    else $error("round counter out of range");

  // A new tag always leaves the chain cleared.
  a_chain_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (chain_r == 128'd0))
    else $error("chain not cleared after tag");

  // No word is taken from the queue while the core is busy.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (st_r == ST_IDLE && q_not_empty))
    else $error("pop while busy or empty");

endmodule
`default_nettype wire

>>> design/aes128_cmac_engine.sv
// Top level of the AES-128 CMAC engine.
//
// Usage: write the key through cfg_we/cfg_index/cfg_wdata (index 0 is the
// upper 64 key bits, index 1 the lower) while the engine is idle. Message
// blocks arrive on the in_ channel, one 16-byte word per handshake, with the
// byte count and a final marker. Non-final words produce nothing; the final
// word of a message produces one 128-bit tag word on the out_ channel.
// Each block is loaded into the iterative AES unit and then runs through
// ten rounds; the core takes no new word until it is done with the last.
// The first final word after reset or a key write waits while the unit
// computes the subkey base L. A two-entry queue lets the in_ side take words
// while the core works. With the core free and L current, the final word
// goes through the queue, the load and ten rounds before its tag is valid.
// Reset clears the chain, the queue and the output valid flag and marks L
// stale. If the receiver stalls, the tag waits in the output register and
// the core holds a following tag until that register frees.
`default_nettype none
module aes128_cmac_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] in_data_high,
  input  wire logic [63:0] in_data_low,
  input  wire logic [4:0]  in_valid_bytes,
  input  wire logic        in_final_block,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_tag_high,
  output logic [63:0]      out_tag_low
);
  import cmac_pkg::*;

  cmac_item_t push_item;
  cmac_item_t head;
  logic       push, full, not_empty, pop;

  cmac_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_high   (in_data_high),
    .in_data_low    (in_data_low),
    .in_valid_bytes (in_valid_bytes),
    .in_final_block (in_final_block),
    .q_full         (full),
    .q_push         (push),
    .q_item         (push_item)
  );

  cmac_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .not_empty (not_empty),
    .pop       (pop),
    .head      (head)
  );

  cmac_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .q_not_empty  (not_empty),
    .q_head       (head),
    .q_pop        (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_tag_high (out_tag_high),
    .out_tag_low  (out_tag_low)
  );

endmodule
`default_nettype wire
